FILE: rtl/ssfe_pkg.sv
`default_nettype none
package ssfe_pkg;

   localparam int DEF_FRAME_WIDTH  = 64;
   localparam int DEF_FRAME_HEIGHT = 64;
   localparam int DEF_STACK_DEPTH  = 64;

   localparam logic [1:0] OPC_WRITE = 2'd0;
   localparam logic [1:0] OPC_READ  = 2'd1;
   localparam logic [1:0] OPC_FILL  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  x_coord;
      logic [5:0]  y_coord;
      logic [23:0] color;
      logic [23:0] border_color;
   } req_type;

   typedef struct packed {
      logic [23:0] read_color;
      logic        status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RD_W, S_SEED_C, S_LEFT_P, S_LEFT_C, S_RIGHT_P, S_RIGHT_C,
      S_POP, S_LATCH, S_PAINT, S_ROW, S_B0_P, S_B0_C, S_B_P, S_B_C, S_A0_P, S_A0_C,
      S_A_P, S_A_C, S_XB, S_SK_P, S_SK_C, S_RUN_P, S_RUN_C, S_NEXTK, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_ACCEPT, OP_READ_LATCH, OP_PR_L, OP_CK_L, OP_PR_R, OP_CK_R,
      OP_POP, OP_LATCH, OP_PAINT, OP_ROW, OP_PR_B, OP_PR_BP1, OP_CK_B, OP_PR_A,
      OP_PR_AM1, OP_CK_A, OP_X_FROM_B, OP_PR_X, OP_CK_SK, OP_CK_RUN, OP_NEXTK,
      OP_LOAD_RSP
   } dp_op_type;

   typedef struct packed {
      logic open;
      logic clear_done;
      logic rsp_free;
      logic stack_empty;
      logic stack_full;
      logic x_le_sr;
      logic x_lt_a;
      logic ny_ok;
      logic k;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/ssfe_ctrl.sv
`default_nettype none
module ssfe_ctrl
   import ssfe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_opcode,
   input  wire dp_status_type st,
   output logic               req_ready,
   output dp_op_type          op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (st.clear_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  OPC_WRITE: state_in = S_DONE;
                  OPC_READ:  state_in = S_RD_W;
                  OPC_FILL:  state_in = S_SEED_C;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_RD_W:    state_in = S_DONE;
         S_SEED_C:  state_in = st.open ? S_LEFT_P : S_DONE;
         S_LEFT_P:  state_in = S_LEFT_C;
         S_LEFT_C:  state_in = st.open ? S_LEFT_P : S_RIGHT_P;
         S_RIGHT_P: state_in = S_RIGHT_C;
         S_RIGHT_C: state_in = st.open ? S_RIGHT_P : S_POP;
         S_POP:     state_in = st.stack_empty ? S_DONE : S_LATCH;
         S_LATCH:   state_in = S_PAINT;
         S_PAINT:   if (!st.x_le_sr) state_in = S_ROW;
         S_ROW: begin
            if (st.ny_ok)  state_in = S_B0_P;
            else if (st.k) state_in = S_POP;
            else           state_in = S_ROW;
         end
         S_B0_P:    state_in = S_B0_C;
         S_B0_C:    state_in = st.open ? S_B_P : S_A0_P;
         S_B_P:     state_in = S_B_C;
         S_B_C:     state_in = st.open ? S_B_P : S_A0_P;
         S_A0_P:    state_in = S_A0_C;
         S_A0_C:    state_in = st.open ? S_A_P : S_XB;
         S_A_P:     state_in = S_A_C;
         S_A_C:     state_in = st.open ? S_A_P : S_XB;
         S_XB:      state_in = S_SK_P;
         S_SK_P:    state_in = st.x_lt_a ? S_NEXTK : S_SK_C;
         S_SK_C:    state_in = st.open ? S_RUN_P : S_SK_P;
         S_RUN_P:   state_in = S_RUN_C;
         S_RUN_C: begin
            if (st.open)            state_in = S_RUN_P;
            else if (st.stack_full) state_in = S_DONE;
            else                    state_in = S_SK_P;
         end
         S_NEXTK:   state_in = st.k ? S_POP : S_ROW;
         S_DONE:    if (st.rsp_free) state_in = S_IDLE;
         default:   state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR:   op = OP_CLEAR;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_ACCEPT;
         end
         S_RD_W:    op = OP_READ_LATCH;
         S_LEFT_P:  op = OP_PR_L;
         S_LEFT_C:  op = OP_CK_L;
         S_RIGHT_P: op = OP_PR_R;
         S_RIGHT_C: op = OP_CK_R;
         S_POP:     if (!st.stack_empty) op = OP_POP;
         S_LATCH:   op = OP_LATCH;
         S_PAINT:   op = OP_PAINT;
         S_ROW:     op = OP_ROW;
         S_B0_P:    op = OP_PR_B;
         S_B_P:     op = OP_PR_BP1;
         S_B_C:     op = OP_CK_B;
         S_A0_P:    op = OP_PR_A;
         S_A_P:     op = OP_PR_AM1;
         S_A_C:     op = OP_CK_A;
         S_XB:      op = OP_X_FROM_B;
         S_SK_P:    if (!st.x_lt_a) op = OP_PR_X;
         S_SK_C:    op = OP_CK_SK;
         S_RUN_P:   op = OP_PR_X;
         S_RUN_C:   op = OP_CK_RUN;
         S_NEXTK:   op = OP_NEXTK;
         S_DONE:    if (st.rsp_free) op = OP_LOAD_RSP;
         default:   op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/ssfe_datapath.sv
`default_nettype none
module ssfe_datapath
   import ssfe_pkg::*;
#(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire dp_op_type op,
   input  wire req_type   req,
   input  wire logic      rsp_ready,
   output logic           rsp_valid,
   output rsp_type        rsp,
   output dp_status_type  st
);

   localparam int CMAX  = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int CW0   = $clog2(CMAX) + 2;
   localparam int CW    = (CW0 < 7) ? 7 : CW0;
   localparam int NPIX  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW    = $clog2(NPIX);
   localparam int SW    = $clog2(STACK_DEPTH);
   localparam logic [AW-1:0] LAST_PIX = AW'(NPIX - 1);
   localparam logic [SW:0]   FULL_CNT = (SW+1)'(STACK_DEPTH);
   localparam logic signed [CW-1:0] ONE = CW'(1);
   localparam logic signed [CW-1:0] W_S = CW'(FRAME_WIDTH);
   localparam logic signed [CW-1:0] H_S = CW'(FRAME_HEIGHT);

   typedef logic signed [CW-1:0] crd_t;

   function automatic logic in_frame(input crd_t px, input crd_t py);
      return (px >= 0) && (px < W_S) && (py >= 0) && (py < H_S);
   endfunction

   function automatic logic [AW-1:0] addr_of(input crd_t px, input crd_t py);
      logic [31:0] t;
      t = 32'(unsigned'(py)) * 32'(FRAME_WIDTH) + 32'(unsigned'(px));
      return t[AW-1:0];
   endfunction

   logic [23:0]      fb_mem [NPIX];
   logic [3*CW-1:0]  stk_mem [STACK_DEPTH];

   logic [23:0] data_q;
   logic        pin_q;
   logic [3*CW-1:0] stk_q;
   logic [AW-1:0] clr_ff;
   logic [SW:0]   cnt_ff;
   logic [23:0]   fill_ff, border_ff;
   crd_t sy_ff, l_ff, r_ff, sl_ff, sr_ff, srow_ff, ny_ff, a_ff, b_ff, x_ff, runr_ff;
   logic k_ff;
   logic [23:0] res_color_ff;
   logic        res_status_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   crd_t rx, ry, px, py, ny_tmp;
   logic ny_ok;
   logic open;
   logic fb_we;
   logic [AW-1:0] fb_wa;
   logic [23:0]   fb_wd;
   logic push;
   logic [3*CW-1:0] push_d;

   assign rx = crd_t'(req.x_coord);
   assign ry = crd_t'(req.y_coord);
   assign open = pin_q && (data_q != fill_ff) && (data_q != border_ff);
   assign ny_tmp = k_ff ? (srow_ff + ONE) : (srow_ff - ONE);
   assign ny_ok = (ny_tmp >= 0) && (ny_tmp < H_S);

   // probe coordinates
   always_comb begin
      px = x_ff;
      py = ny_ff;
      case (op)
         OP_ACCEPT: begin px = rx;          py = ry;    end
         OP_PR_L:   begin px = l_ff - ONE;  py = sy_ff; end
         OP_PR_R:   begin px = r_ff + ONE;  py = sy_ff; end
         OP_PR_B:   begin px = b_ff;        py = ny_ff; end
         OP_PR_BP1: begin px = b_ff + ONE;  py = ny_ff; end
         OP_PR_A:   begin px = a_ff;        py = ny_ff; end
         OP_PR_AM1: begin px = a_ff - ONE;  py = ny_ff; end
         OP_PR_X:   begin px = x_ff;        py = ny_ff; end
         default:   begin px = x_ff;        py = ny_ff; end
      endcase
   end

   // frame buffer write port
   always_comb begin
      fb_we = 1'b0;
      fb_wa = clr_ff;
      fb_wd = 24'd0;
      case (op)
         OP_CLEAR: fb_we = 1'b1;
         OP_ACCEPT: begin
            fb_we = (req.opcode == OPC_WRITE) && in_frame(rx, ry);
            fb_wa = addr_of(rx, ry);
            fb_wd = req.color;
         end
         OP_PAINT: begin
            fb_we = (x_ff <= sr_ff) && in_frame(x_ff, srow_ff);
            fb_wa = addr_of(x_ff, srow_ff);
            fb_wd = fill_ff;
         end
         default: fb_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fb_we) fb_mem[fb_wa] <= fb_wd;
      data_q <= fb_mem[addr_of(px, py)];
      pin_q  <= in_frame(px, py);
   end

   // span stack
   always_comb begin
      push   = 1'b0;
      push_d = {l_ff, r_ff, sy_ff};
      case (op)
         OP_CK_R: push = !open;
         OP_CK_RUN: begin
            push   = !open && (cnt_ff != FULL_CNT);
            push_d = {x_ff + ONE, runr_ff, ny_ff};
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) stk_mem[cnt_ff[SW-1:0]] <= push_d;
      stk_q <= stk_mem[SW'(cnt_ff - 1'b1)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == OP_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (push) cnt_ff <= cnt_ff + 1'b1;
         else if (op == OP_POP) cnt_ff <= cnt_ff - 1'b1;
         else if (op == OP_CK_RUN && !open) cnt_ff <= '0;
         if (op == OP_LOAD_RSP) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_ACCEPT: begin
            fill_ff       <= req.color;
            border_ff     <= req.border_color;
            sy_ff         <= ry;
            l_ff          <= rx;
            r_ff          <= rx;
            res_color_ff  <= 24'd0;
            res_status_ff <= 1'b0;
         end
         OP_READ_LATCH: res_color_ff <= pin_q ? data_q : 24'd0;
         OP_CK_L: if (open) l_ff <= l_ff - ONE;
         OP_CK_R: if (open) r_ff <= r_ff + ONE;
         OP_LATCH: begin
            sl_ff   <= stk_q[3*CW-1:2*CW];
            sr_ff   <= stk_q[2*CW-1:CW];
            srow_ff <= stk_q[CW-1:0];
            x_ff    <= stk_q[3*CW-1:2*CW];
            k_ff    <= 1'b0;
         end
         OP_PAINT: if (x_ff <= sr_ff) x_ff <= x_ff + ONE;
         OP_ROW: begin
            if (ny_ok) begin
               ny_ff <= ny_tmp;
               a_ff  <= sl_ff;
               b_ff  <= sr_ff;
            end else begin
               k_ff  <= 1'b1;
            end
         end
         OP_CK_B: if (open) b_ff <= b_ff + ONE;
         OP_CK_A: if (open) a_ff <= a_ff - ONE;
         OP_X_FROM_B: x_ff <= b_ff;
         OP_CK_SK: begin
            if (open) runr_ff <= x_ff;
            x_ff <= x_ff - ONE;
         end
         OP_CK_RUN: begin
            if (open) x_ff <= x_ff - ONE;
            else if (cnt_ff == FULL_CNT) res_status_ff <= 1'b1;
         end
         OP_NEXTK: k_ff <= 1'b1;
         OP_LOAD_RSP: begin
            rsp_ff.read_color <= res_color_ff;
            rsp_ff.status     <= res_status_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      st.open        = open;
      st.clear_done  = (clr_ff == LAST_PIX);
      st.rsp_free    = !rsp_valid_ff || rsp_ready;
      st.stack_empty = (cnt_ff == '0);
      st.stack_full  = (cnt_ff == FULL_CNT);
      st.x_le_sr     = (x_ff <= sr_ff);
      st.x_lt_a      = (x_ff < a_ff);
      st.ny_ok       = ny_ok;
      st.k           = k_ff;
   end

endmodule
`default_nettype wire

FILE: rtl/scanline_seed_fill_engine_top.sv
`default_nettype none
// Channel   Ports                         Transaction
// request   req_valid/req_ready, req      one command: write, read or fill
// response  rsp_valid/rsp_ready, rsp      one result per command
//
// Write and unused opcode: accept, then the response register. Read adds a state
// that latches the frame buffer data. Fill: each pixel probe on the frame buffer
// read port is a probe state and a check state, and each painted pixel one step.
// After reset the frame buffer is cleared, one pixel a cycle, with req_ready low.
// A waiting response does not block the next request; the engine stalls
// only at the end of a command while the response register is still full.
module scanline_seed_fill_engine_top
   import ssfe_pkg::*;
#(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   dp_op_type     op;
   dp_status_type st;

   // sequencer: walks the span stack algorithm, one probe or paint per step
   ssfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req.opcode),
      .st         (st),
      .req_ready  (req_ready),
      .op         (op)
   );

   // frame buffer, span stack, coordinate registers, response register
   ssfe_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req       (req),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .st        (st)
   );

endmodule
`default_nettype wire

FILE: rtl/ssfe_checker.sv
`default_nettype none
module ssfe_checker
   import ssfe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("engine active during clearing");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_status_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status |-> rsp.read_color == 24'd0)
      else $error("overflow status with non-zero colour");

endmodule

bind scanline_seed_fill_engine_top ssfe_checker u_chk (.*);
`default_nettype wire

FILE: dv/tb_scanline_seed_fill_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_scanline_seed_fill_engine_top;
   import ssfe_pkg::*;

   localparam int FW = DEF_FRAME_WIDTH;
   localparam int FH = DEF_FRAME_HEIGHT;
   localparam int SD = DEF_STACK_DEPTH;
   localparam logic [1:0] OPC_SPARE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   scanline_seed_fill_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Shadow frame and span stack for the prediction
   logic [23:0] shadow_pix [FW*FH];
   int          span_l [SD];
   int          span_r [SD];
   int          span_y [SD];
   int          span_cnt;

   rsp_type     expected_rsp_q [$];
   int          mismatch_count = 0;
   int          rsp_count = 0;
   int          fill_count = 0;
   int          overflow_count = 0;

   // Sender and receiver idling controls
   bit          send_idle_en = 1'b1;
   bit          recv_idle_en = 1'b1;
   // hold-off request from the tests; the receiver counts the cycles itself
   int          recv_hold_len = 0;
   int          hold_req_count = 0;
   int          hold_ack_count = 0;
   int          recv_hold_cycles = 0;

   function automatic bit pix_open(int x, int y, logic [23:0] f, logic [23:0] b);
      logic [23:0] c;
      if (x < 0 || x >= FW || y < 0 || y >= FH) return 1'b0;
      c = shadow_pix[y*FW + x];
      return c != f && c != b;
   endfunction

   function automatic bit span_push(int l, int r, int y);
      if (span_cnt >= SD) return 1'b0;
      span_l[span_cnt] = l;
      span_r[span_cnt] = r;
      span_y[span_cnt] = y;
      span_cnt++;
      return 1'b1;
   endfunction

   // Boundary fill on the shadow frame; returns overflow status
   function automatic logic fill_region(int sx, int sy, logic [23:0] f, logic [23:0] b);
      int l, r, x, ny, a, e, run_r, pl, pr, py;
      span_cnt = 0;
      if (!pix_open(sx, sy, f, b)) return 1'b0;
      l = sx;
      while (pix_open(l-1, sy, f, b)) l--;
      r = sx;
      while (pix_open(r+1, sy, f, b)) r++;
      void'(span_push(l, r, sy));
      while (span_cnt != 0) begin
         span_cnt--;
         pl = span_l[span_cnt];
         pr = span_r[span_cnt];
         py = span_y[span_cnt];
         for (x = pl; x <= pr; x++)
            if (x >= 0 && x < FW && py >= 0 && py < FH) shadow_pix[py*FW + x] = f;
         for (int k = 0; k < 2; k++) begin
            ny = (k == 0) ? py - 1 : py + 1;
            if (ny < 0 || ny >= FH) continue;
            a = pl;
            e = pr;
            if (pix_open(e, ny, f, b))
               while (pix_open(e+1, ny, f, b)) e++;
            if (pix_open(a, ny, f, b))
               while (pix_open(a-1, ny, f, b)) a--;
            x = e;
            while (x >= a) begin
               while (x >= a && !pix_open(x, ny, f, b)) x--;
               if (x < a) break;
               run_r = x;
               while (pix_open(x, ny, f, b)) x--;
               if (!span_push(x+1, run_r, ny)) begin
                  span_cnt = 0;
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_cmd(req_type c);
      rsp_type o;
      o = '0;
      case (c.opcode)
         OPC_WRITE: shadow_pix[c.y_coord*FW + c.x_coord] = c.color;
         OPC_READ:  o.read_color = shadow_pix[c.y_coord*FW + c.x_coord];
         OPC_FILL: begin
            o.status = fill_region(int'(c.x_coord), int'(c.y_coord), c.color,
                                   c.border_color);
            fill_count++;
            if (o.status) overflow_count++;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Send one command: random idle gap if enabled, then hold valid until accepted
   task automatic send_cmd(req_type c);
      if (send_idle_en)
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req <= c;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(predict_cmd(c));
   endtask

   task automatic send_op(logic [1:0] op, int x, int y, logic [23:0] c, logic [23:0] b);
      req_type t;
      t.opcode = op;
      t.x_coord = 6'(x);
      t.y_coord = 6'(y);
      t.color = c;
      t.border_color = b;
      send_cmd(t);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Receiver: random stalls if enabled, plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready        <= 1'b0;
         recv_hold_cycles <= 0;
         hold_ack_count   <= 0;
      end else if (hold_ack_count != hold_req_count) begin
         hold_ack_count   <= hold_req_count;
         recv_hold_cycles <= recv_hold_len;
         rsp_ready        <= 1'b0;
      end else if (recv_hold_cycles > 0) begin
         recv_hold_cycles <= recv_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= recv_idle_en ? ($urandom_range(99) >= 33) : 1'b1;
      end
   end

   // Checker: every response transaction against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp), 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp.read_color !== want.read_color)
               report_mismatch("read_color", 32'(rsp.read_color), 32'(want.read_color));
            if (rsp.status !== want.status)
               report_mismatch("status", 32'(rsp.status), 32'(want.status));
         end
      end
   end

   task automatic test_directed();
      send_op(OPC_READ, 0, 0, 24'h123456, 24'h0);      // cleared frame reads zero
      send_op(OPC_WRITE, 0, 0, 24'hFFFFFF, 24'h0);
      send_op(OPC_WRITE, 63, 63, 24'hA5A5A5, 24'h0);
      send_op(OPC_READ, 0, 0, 24'h0, 24'hFFFFFF);
      send_op(OPC_READ, 63, 63, 24'h0, 24'h0);
      send_op(OPC_SPARE, 5, 5, 24'hFFFFFF, 24'hFFFFFF);
      // box of border 0x0000FF with gaps in its sides, filled from inside
      for (int i = 10; i <= 14; i++) begin
         send_op(OPC_WRITE, i, 10, 24'h0000FF, 24'h0);
         send_op(OPC_WRITE, i, 14, 24'h0000FF, 24'h0);
      end
      send_op(OPC_WRITE, 10, 12, 24'h0000FF, 24'h0);
      send_op(OPC_WRITE, 14, 12, 24'h0000FF, 24'h0);
      send_op(OPC_FILL, 12, 12, 24'h00FF00, 24'h0000FF);
      send_op(OPC_FILL, 12, 12, 24'h00FF00, 24'h0000FF); // seed already fill colour
      send_op(OPC_FILL, 10, 10, 24'h00FF00, 24'h0000FF); // seed on border
      send_op(OPC_READ, 12, 12, 24'h0, 24'h0);
      wait_drain();
   endtask

   task automatic test_full_frame_fill();
      // open frame: flood the whole screen, then read back a far corner
      send_op(OPC_FILL, 30, 30, 24'h112233, 24'hFFFFFF);
      send_op(OPC_READ, 0, 63, 24'h0, 24'h0);
      wait_drain();
   endtask

   task automatic test_overflow();
      // two combed rows of border dots give many short runs, stacked twice each
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      for (int x = 1; x < 32; x += 2) begin
         send_op(OPC_WRITE, x, 36, 24'hFFFFFF, 24'h0);
         send_op(OPC_WRITE, x, 45, 24'hFFFFFF, 24'h0);
      end
      send_op(OPC_FILL, 0, 32, 24'h445566, 24'hFFFFFF);
      send_op(OPC_FILL, 2, 5, 24'h778899, 24'hFFFFFF);
      wait_drain();
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
   endtask

   task automatic test_backpressure();
      // receiver holds off while commands keep coming
      recv_hold_len = 400;
      hold_req_count++;
      for (int i = 0; i < 12; i++)
         send_op(2'($urandom_range(1)), $urandom_range(63), $urandom_range(63),
                 24'($urandom()), 24'($urandom()));
      wait_drain();
   endtask

   task automatic test_random(int n);
      req_type t;
      for (int i = 0; i < n; i++) begin
         if (i == n/2) begin
            send_idle_en = 1'b0;
            recv_idle_en = 1'b0;
         end
         if (i == n*3/4) begin
            send_idle_en = 1'b1;
            recv_idle_en = 1'b1;
         end
         t.opcode = ($urandom_range(9) < 2) ? OPC_FILL : 2'($urandom_range(3));
         if (t.opcode == OPC_FILL && $urandom_range(1)) begin
            // small palette makes fills meet borders and prior fills
            t.color = 24'($urandom_range(3));
            t.border_color = 24'($urandom_range(3));
         end else begin
            t.color = 24'($urandom());
            t.border_color = 24'($urandom());
         end
         if (t.opcode == OPC_WRITE && $urandom_range(1)) t.color = 24'($urandom_range(3));
         t.x_coord = 6'($urandom());
         t.y_coord = 6'($urandom());
         send_cmd(t);
      end
      wait_drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (shadow_pix[i]) shadow_pix[i] = '0;
      test_directed();
      test_full_frame_fill();
      test_overflow();
      test_backpressure();
      test_random(30);
      $display("Covered %0d responses, %0d fills of which %0d hit stack overflow.",
               rsp_count, fill_count, overflow_count);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
rtl/ssfe_pkg.sv
rtl/ssfe_ctrl.sv
rtl/ssfe_datapath.sv
rtl/scanline_seed_fill_engine_top.sv
rtl/ssfe_checker.sv
dv/tb_scanline_seed_fill_engine_top.sv
